FILE: rtl/lef_pkg.sv
// Shared types, constants and helpers for the Laplacian edge filter.
package lef_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = 16;
  localparam int WIDTH_BITS = 11;
  localparam int DATA_BITS  = 16;
  localparam int SUM_BITS   = PIXEL_BITS + 2;
  localparam int LAP_BITS   = SUM_BITS + 1;
  localparam int EDGE_BITS  = 8;
  localparam int RECENT_DEPTH = 2;

  localparam logic [EDGE_BITS-1:0] EDGE_MAX = 8'd255;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    pixel_t up;
    pixel_t down;
    pixel_t left;
    pixel_t right;
    pixel_t centre;
  } stencil_taps_t;

  // Last column index for a programmed width, width held to 2..MAX_WIDTH.
  function automatic logic [COL_BITS-1:0] width_last(input logic [WIDTH_BITS-1:0] w);
    logic [WIDTH_BITS-1:0] t;
    begin
      if (w < WIDTH_BITS'(2)) begin
        t = WIDTH_BITS'(1);
      end else if (w > WIDTH_BITS'(MAX_WIDTH)) begin
        t = WIDTH_BITS'(MAX_WIDTH - 1);
      end else begin
        t = w - WIDTH_BITS'(1);
      end
      return t[COL_BITS-1:0];
    end
  endfunction

  // Last row index for a programmed height, height held to at least 2.
  function automatic logic [ROW_BITS-1:0] height_last(input logic [ROW_BITS-1:0] h);
    logic [ROW_BITS-1:0] t;
    begin
      if (h < ROW_BITS'(2)) begin
        t = ROW_BITS'(1);
      end else begin
        t = h - ROW_BITS'(1);
      end
      return t;
    end
  endfunction

endpackage

FILE: rtl/lef_line_bank.sv
// One bank of the line store: one write port, two registered read ports.
module lef_line_bank (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lef_pkg::COL_BITS-1:0] waddr,
  input  lef_pkg::pixel_t             wdata,
  input  logic                        re,
  input  logic [lef_pkg::COL_BITS-1:0] raddr_a,
  input  logic [lef_pkg::COL_BITS-1:0] raddr_b,
  output lef_pkg::pixel_t             qa,
  output lef_pkg::pixel_t             qb
);

  lef_pkg::pixel_t mem [lef_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      qa <= mem[raddr_a];
      qb <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/lef_tap_cell.sv
// One cell of the recent-pixel chain: holds a pixel, passes it on each shift.
module lef_tap_cell (
  input  logic            clk,
  input  logic            shift,
  input  lef_pkg::pixel_t d,
  output lef_pkg::pixel_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: rtl/lef_stencil.sv
// Four-neighbour Laplacian kernel with clamp to 0..255.
module lef_stencil (
  input  lef_pkg::stencil_taps_t               taps,
  output logic signed [lef_pkg::LAP_BITS-1:0] laplacian,
  output logic [lef_pkg::EDGE_BITS-1:0]        edge_level
);

  logic [lef_pkg::SUM_BITS-1:0] sum;
  logic [lef_pkg::SUM_BITS-1:0] quad;

  always_comb begin
    sum = lef_pkg::SUM_BITS'(taps.up) + lef_pkg::SUM_BITS'(taps.down)
        + lef_pkg::SUM_BITS'(taps.left) + lef_pkg::SUM_BITS'(taps.right);
    quad = {taps.centre, 2'b00};
    laplacian = $signed({1'b0, sum}) - $signed({1'b0, quad});
    if (laplacian[lef_pkg::LAP_BITS-1]) begin
      edge_level = '0;
    end else if (laplacian[lef_pkg::LAP_BITS-2:lef_pkg::EDGE_BITS] != '0) begin
      edge_level = lef_pkg::EDGE_MAX;
    end else begin
      edge_level = laplacian[lef_pkg::EDGE_BITS-1:0];
    end
  end

endmodule

FILE: rtl/laplacian_edge_filter_top.sv
// Top level of the streaming four-neighbour Laplacian edge filter.
//
// Pixels enter in raster order on pixel/pixel_valid/pixel_stall; a word is
// taken when pixel_valid is high and pixel_stall low. Results leave on the
// result channel under the same rule, one stencil pixel per word, tagged
// with out_row/out_col, last_in_run and frame_done.
// Results lag the input by one row: the pixel at (r, c) completes (r-1, c).
// Pixels of row 0 give no word. On the last row a pixel also completes its
// left neighbor, and the final pixel completes itself, so one pixel gives up
// to three words; pixel_stall holds the input while the extra words go out.
// A word passes through the compute-stage registers and the output register
// to the result port. Throughput: one pixel per cycle unless result_stall or
// extra last-row words hold the input, set by the single compute stage that
// feeds the output register. A pixel writes one bank, reads two from each.
// A result_stall holds the output register; the compute stage then holds its
// pixel and pixel_stall rises. Reset (rst, synchronous) sets width and height
// to 1024 and restarts the frame. A write to either register also restarts
// the frame; line-store contents are kept and need no clearing.
module laplacian_edge_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [lef_pkg::DATA_BITS-1:0]        cfg_data,
  input  logic [lef_pkg::PIXEL_BITS-1:0]       pixel,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  output logic signed [lef_pkg::LAP_BITS-1:0]  laplacian,
  output logic [lef_pkg::EDGE_BITS-1:0]        edge_level,
  output logic [lef_pkg::ROW_BITS-1:0]         out_row,
  output logic [lef_pkg::COL_BITS-1:0]         out_col,
  output logic                                 last_in_run,
  output logic                                 frame_done,
  output logic                                 result_valid,
  input  logic                                 result_stall
);

  typedef enum logic [2:0] {
    SEL_MAIN  = 3'b001,
    SEL_LEFT  = 3'b010,
    SEL_FINAL = 3'b100
  } sel_t;

  // frame position and geometry
  logic [lef_pkg::ROW_BITS-1:0] row_count;
  logic [lef_pkg::COL_BITS-1:0] col_count;
  logic [lef_pkg::COL_BITS-1:0] w_last;
  logic [lef_pkg::ROW_BITS-1:0] h_last;
  logic                         row_end;
  logic                         last_row;
  logic                         accept;

  // compute stage
  logic                         s1_valid;
  lef_pkg::pixel_t              s1_pixel;
  logic [lef_pkg::ROW_BITS-1:0] s1_row;
  logic [lef_pkg::COL_BITS-1:0] s1_col;
  logic                         s1_row_end;
  logic                         s1_last_row;
  logic                         s1_par;
  logic                         s1_second_row;
  sel_t                         sel;
  sel_t                         sel_after;
  logic                         more;
  logic                         left_en;
  logic                         fin_en;
  logic                         out_load;
  logic                         s1_done;

  // line store and window
  lef_pkg::pixel_t              q_near [2];
  lef_pkg::pixel_t              q_far [2];
  lef_pkg::pixel_t              up_rd;
  lef_pkg::pixel_t              mid_rd;
  lef_pkg::pixel_t              right_rd;
  lef_pkg::pixel_t              prev_left;
  lef_pkg::pixel_t              recent [lef_pkg::RECENT_DEPTH];

  lef_pkg::stencil_taps_t       taps;
  logic [lef_pkg::ROW_BITS-1:0] res_row;
  logic [lef_pkg::COL_BITS-1:0] res_col;
  logic                         res_done;
  logic signed [lef_pkg::LAP_BITS-1:0] lap_calc;
  logic [lef_pkg::EDGE_BITS-1:0]       edge_calc;

  assign row_end  = col_count >= w_last;
  assign last_row = row_count >= h_last;

  assign left_en  = s1_last_row && (s1_col != '0);
  assign fin_en   = s1_last_row && s1_row_end;
  assign out_load = s1_valid && (!result_valid || !result_stall);
  assign s1_done  = out_load && !more;
  assign pixel_stall = s1_valid && !s1_done;
  assign accept   = pixel_valid && !pixel_stall;

  always_comb begin
    case (sel)
      SEL_MAIN: begin
        more = left_en || fin_en;
        sel_after = left_en ? SEL_LEFT : SEL_FINAL;
      end
      SEL_LEFT: begin
        more = fin_en;
        sel_after = SEL_FINAL;
      end
      default: begin
        more = 1'b0;
        sel_after = SEL_FINAL;
      end
    endcase
  end

  // two banks, selected by row parity
  for (genvar b = 0; b < 2; b++) begin : g_bank
    lef_line_bank u_bank (
      .clk     (clk),
      .we      (accept && (row_count[0] == 1'(b))),
      .waddr   (col_count),
      .wdata   (pixel),
      .re      (accept),
      .raddr_a (col_count),
      .raddr_b (col_count + lef_pkg::COL_BITS'(1)),
      .qa      (q_near[b]),
      .qb      (q_far[b])
    );
  end

  assign up_rd    = q_near[s1_par];
  assign mid_rd   = q_near[~s1_par];
  assign right_rd = q_far[~s1_par];

  for (genvar i = 0; i < lef_pkg::RECENT_DEPTH; i++) begin : g_recent
    if (i == 0) begin : g_head
      lef_tap_cell u_cell (.clk(clk), .shift(accept), .d(s1_pixel), .q(recent[i]));
    end else begin : g_tail
      lef_tap_cell u_cell (.clk(clk), .shift(accept), .d(recent[i-1]), .q(recent[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_left     <= mid_rd;
      s1_pixel      <= pixel;
      s1_row        <= row_count;
      s1_col        <= col_count;
      s1_row_end    <= row_end;
      s1_last_row   <= last_row;
      s1_par        <= row_count[0];
      s1_second_row <= row_count == lef_pkg::ROW_BITS'(1);
    end
  end

  always_comb begin
    case (sel)
      SEL_MAIN: begin
        taps.centre = mid_rd;
        taps.up     = s1_second_row ? mid_rd : up_rd;
        taps.left   = (s1_col == '0) ? mid_rd : prev_left;
        taps.right  = s1_row_end ? mid_rd : right_rd;
        taps.down   = s1_pixel;
        res_row     = s1_row - lef_pkg::ROW_BITS'(1);
        res_col     = s1_col;
        res_done    = 1'b0;
      end
      SEL_LEFT: begin
        taps.centre = recent[0];
        taps.up     = prev_left;
        taps.left   = (s1_col == lef_pkg::COL_BITS'(1)) ? recent[0] : recent[1];
        taps.right  = s1_pixel;
        taps.down   = recent[0];
        res_row     = s1_row;
        res_col     = s1_col - lef_pkg::COL_BITS'(1);
        res_done    = 1'b0;
      end
      default: begin
        taps.centre = s1_pixel;
        taps.up     = mid_rd;
        taps.left   = (s1_col == '0) ? s1_pixel : recent[0];
        taps.right  = s1_pixel;
        taps.down   = s1_pixel;
        res_row     = s1_row;
        res_col     = s1_col;
        res_done    = 1'b1;
      end
    endcase
  end

  lef_stencil u_stencil (
    .taps       (taps),
    .laplacian  (lap_calc),
    .edge_level (edge_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      col_count    <= '0;
      w_last       <= lef_pkg::width_last(lef_pkg::WIDTH_BITS'(1024));
      h_last       <= lef_pkg::height_last(lef_pkg::ROW_BITS'(1024));
      s1_valid     <= 1'b0;
      sel          <= SEL_MAIN;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        row_count <= '0;
        col_count <= '0;
        case (cfg_index)
          lef_pkg::CFG_IMAGE_WIDTH: begin
            w_last <= lef_pkg::width_last(cfg_data[lef_pkg::WIDTH_BITS-1:0]);
          end
          lef_pkg::CFG_IMAGE_HEIGHT: begin
            h_last <= lef_pkg::height_last(cfg_data);
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        if (row_end) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + lef_pkg::ROW_BITS'(1);
        end else begin
          col_count <= col_count + lef_pkg::COL_BITS'(1);
        end
      end

      if (accept) begin
        s1_valid <= row_count != '0;
        sel      <= SEL_MAIN;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (out_load) begin
        sel <= sel_after;
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      laplacian   <= lap_calc;
      edge_level  <= edge_calc;
      out_row     <= res_row;
      out_col     <= res_col;
      last_in_run <= !more;
      frame_done  <= res_done;
    end
  end

`ifndef SYNTH
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    col_count <= w_last)
    else $error("column counter past row end");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    row_count <= h_last)
    else $error("row counter past frame end");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !pixel_stall)
    else $error("input stalled with compute stage empty");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_load && res_done |=> result_valid && last_in_run)
    else $error("frame end word not last of its run");
`endif

endmodule
